[hw/rtl/bfpsc_pkg.sv]
package bfpsc_pkg;

    // Frame marker bytes.
    localparam logic [7:0] START_BYTE = 8'h3a;
    localparam logic [7:0] END_BYTE_1 = 8'h0d;
    localparam logic [7:0] END_BYTE_2 = 8'h0a;

    // Parse phase codes.
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_ADDR1 = 4'd1;
    localparam logic [3:0] PH_ADDR2 = 4'd2;
    localparam logic [3:0] PH_FUNC1 = 4'd3;
    localparam logic [3:0] PH_FUNC2 = 4'd4;
    localparam logic [3:0] PH_LEN1  = 4'd5;
    localparam logic [3:0] PH_LEN2  = 4'd6;
    localparam logic [3:0] PH_DATA  = 4'd7;
    localparam logic [3:0] PH_CHK1  = 4'd8;
    localparam logic [3:0] PH_CHK2  = 4'd9;
    localparam logic [3:0] PH_END1  = 4'd10;
    localparam logic [3:0] PH_END2  = 4'd11;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_START    = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;
    localparam logic [1:0] ERR_END      = 2'd3;

    localparam int RES_DATA_W = 72;

    typedef struct packed {
        logic [1:0]  error_code;
        logic [15:0] payload_length;
        logic [15:0] function_code;
        logic [7:0]  frame_address;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        logic [1:0]  kind;
    } res_t;

endpackage

[hw/rtl/bfpsc_parser.sv]
module bfpsc_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    output bfpsc_pkg::res_t    res
);

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  addr_reg, addr_next;
    logic [15:0] func_reg, func_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] word;
    logic        frame_fields;

    assign word = {rx_byte, held_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        addr_next    = addr_reg;
        func_next    = func_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        res_valid    = 1'b0;
        frame_fields = 1'b1;
        res.kind         = bfpsc_pkg::KIND_ERROR;
        res.payload_byte = 8'd0;
        res.payload_index = 16'd0;
        res.error_code   = bfpsc_pkg::ERR_NONE;

        unique case (phase_reg)
            bfpsc_pkg::PH_ADDR1:
            begin
                held_next  = rx_byte;
                phase_next = bfpsc_pkg::PH_ADDR2;
            end
            bfpsc_pkg::PH_ADDR2:
            begin
                // Only the first address byte is kept; the second is dropped.
                addr_next  = held_reg;
                sum_next   = {8'd0, held_reg};
                phase_next = bfpsc_pkg::PH_FUNC1;
            end
            bfpsc_pkg::PH_FUNC1:
            begin
                held_next  = rx_byte;
                phase_next = bfpsc_pkg::PH_FUNC2;
            end
            bfpsc_pkg::PH_FUNC2:
            begin
                func_next  = word;
                sum_next   = sum_reg + {8'd0, held_reg} + {8'd0, rx_byte};
                phase_next = bfpsc_pkg::PH_LEN1;
            end
            bfpsc_pkg::PH_LEN1:
            begin
                held_next  = rx_byte;
                phase_next = bfpsc_pkg::PH_LEN2;
            end
            bfpsc_pkg::PH_LEN2:
            begin
                len_next   = word;
                sum_next   = sum_reg + word;
                count_next = 16'd0;
                phase_next = (word != 16'd0) ? bfpsc_pkg::PH_DATA : bfpsc_pkg::PH_CHK1;
            end
            bfpsc_pkg::PH_DATA:
            begin
                sum_next   = sum_reg + {8'd0, rx_byte};
                count_next = count_reg + 16'd1;
                if (({1'b0, count_reg} + 17'd1) >= {1'b0, len_reg})
                begin
                    phase_next = bfpsc_pkg::PH_CHK1;
                end
                res_valid         = 1'b1;
                res.kind          = bfpsc_pkg::KIND_PAYLOAD;
                res.payload_byte  = rx_byte;
                res.payload_index = count_reg;
            end
            bfpsc_pkg::PH_CHK1:
            begin
                held_next  = rx_byte;
                phase_next = bfpsc_pkg::PH_CHK2;
            end
            bfpsc_pkg::PH_CHK2:
            begin
                if (word != sum_reg)
                begin
                    phase_next     = bfpsc_pkg::PH_START;
                    res_valid      = 1'b1;
                    res.error_code = bfpsc_pkg::ERR_CHECKSUM;
                end
                else
                begin
                    phase_next = bfpsc_pkg::PH_END1;
                end
            end
            bfpsc_pkg::PH_END1:
            begin
                if (rx_byte != bfpsc_pkg::END_BYTE_1)
                begin
                    phase_next     = bfpsc_pkg::PH_START;
                    res_valid      = 1'b1;
                    res.error_code = bfpsc_pkg::ERR_END;
                end
                else
                begin
                    phase_next = bfpsc_pkg::PH_END2;
                end
            end
            bfpsc_pkg::PH_END2:
            begin
                phase_next = bfpsc_pkg::PH_START;
                res_valid  = 1'b1;
                if (rx_byte != bfpsc_pkg::END_BYTE_2)
                begin
                    res.error_code = bfpsc_pkg::ERR_END;
                end
                else
                begin
                    res.kind = bfpsc_pkg::KIND_DONE;
                end
            end
            default:
            begin
                // Waiting for a start byte; unused phase codes land here too.
                if (rx_byte != bfpsc_pkg::START_BYTE)
                begin
                    phase_next     = bfpsc_pkg::PH_START;
                    res_valid      = 1'b1;
                    res.error_code = bfpsc_pkg::ERR_START;
                    frame_fields   = 1'b0;
                end
                else
                begin
                    phase_next = bfpsc_pkg::PH_ADDR1;
                end
            end
        endcase

        res.frame_address  = frame_fields ? addr_reg : 8'd0;
        res.function_code  = frame_fields ? func_reg : 16'd0;
        res.payload_length = frame_fields ? len_reg : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bfpsc_pkg::PH_START;
            held_reg  <= 8'd0;
            addr_reg  <= 8'd0;
            func_reg  <= 16'd0;
            len_reg   <= 16'd0;
            count_reg <= 16'd0;
            sum_reg   <= 16'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            addr_reg  <= addr_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

[hw/rtl/binary_frame_parser_with_sum_check_top.sv]
// Channel  | Direction | tdata                      | tuser | Note
// s_axis   | in        | rx_byte[7:0]               | -     | one received byte per item
// m_axis   | out       | see m_axis_tdata below     | kind  | zero or one result per byte
//
// One item is accepted per cycle while m_axis_tready does not hold the result register.
// The byte sits in an input register, passes through the parser logic, and lands in the
// result register. When the result register is held by m_axis_tready low, the input
// register keeps one more byte and then s_axis_tready drops.
// The asynchronous reset returns the parser to waiting for a start byte and clears all sums.
module binary_frame_parser_with_sum_check_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_address,
    // [47:32] function_code, [63:48] payload_length, [65:64] error_code, rest zero
    output logic [bfpsc_pkg::RES_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    logic            in_valid_reg, in_valid_next;
    logic [7:0]      in_byte_reg;
    logic            out_valid_reg, out_valid_next;
    bfpsc_pkg::res_t out_res_reg;
    logic            advance;
    logic            res_valid;
    bfpsc_pkg::res_t res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    bfpsc_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {6'd0, out_res_reg.error_code, out_res_reg.payload_length,
                            out_res_reg.function_code, out_res_reg.frame_address,
                            out_res_reg.payload_index, out_res_reg.payload_byte};

    // A byte waiting behind a stalled result must not be dropped.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |=> in_valid_reg)
        else $error("input item lost while result stalled");

    // An accepted item is always captured in the input register.
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted item not captured");

    // A payload result carries no error and lies inside the declared length.
    a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.kind == bfpsc_pkg::KIND_PAYLOAD) |->
        (out_res_reg.error_code == bfpsc_pkg::ERR_NONE &&
         out_res_reg.payload_index < out_res_reg.payload_length))
        else $error("payload result out of range");

endmodule
